// ===== sv/rast_pkg.sv =====
`default_nettype none

package rast_pkg;

  localparam int RAST_ENTRIES = 32;

  localparam int TIME_W   = 64;
  localparam int ADDR_W   = 32;
  localparam int PORT_W   = 16;
  localparam int KIND_W   = 3;
  localparam int LEVEL_W  = 2;
  localparam int PERIOD_W = 32;
  localparam int OUTC_W   = 2;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 32'd30000;

  typedef enum logic [OUTC_W-1:0] {
    OUT_STORED     = 2'd0,
    OUT_REFRESHED  = 2'd1,
    OUT_SUPPRESSED = 2'd2,
    OUT_FULL       = 2'd3
  } outcome_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [PORT_W-1:0]  port;
    logic [KIND_W-1:0]  kind;
    logic [LEVEL_W-1:0] level;
  } rast_key_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic      eval;
    logic      commit;
    logic      any_match;
    rast_key_t key;
    logic [TIME_W-1:0]   now;
    logic [PERIOD_W-1:0] period;
  } rast_cmd_t;

  // Handed from one cell to its higher-numbered neighbor.
  typedef struct packed {
    logic hit;
    logic hit_stale;
    logic free_seen;
  } rast_link_t;

endpackage

`default_nettype wire

// ===== sv/rast_if.sv =====
`default_nettype none

interface rast_in_if;
  import rast_pkg::*;
  logic                valid;
  logic                ready;
  logic [TIME_W-1:0]   now_ms;
  logic [ADDR_W-1:0]   server_addr;
  logic [PORT_W-1:0]   server_port;
  logic [KIND_W-1:0]   violation_code;
  logic [LEVEL_W-1:0]  severity;

  modport source (output valid, now_ms, server_addr, server_port, violation_code, severity,
                  input ready);
  modport sink (input valid, now_ms, server_addr, server_port, violation_code, severity,
                output ready);
endinterface

interface rast_out_if;
  import rast_pkg::*;
  logic              valid;
  logic              ready;
  logic              redundant;
  logic [OUTC_W-1:0] outcome;

  modport source (output valid, redundant, outcome, input ready);
  modport sink (input valid, redundant, outcome, output ready);
endinterface

interface rast_cfg_if;
  import rast_pkg::*;
  logic                valid;
  logic                ready;
  logic [PERIOD_W-1:0] recheck_period_ms;

  modport source (output valid, recheck_period_ms, input ready);
  modport sink (input valid, recheck_period_ms, output ready);
endinterface

`default_nettype wire

// ===== sv/rast_cell.sv =====
`default_nettype none

module rast_cell (
  input  wire                  clk,
  input  wire                  rst_n,
  input  rast_pkg::rast_cmd_t  cmd,
  input  rast_pkg::rast_link_t link_in,
  output rast_pkg::rast_link_t link_out
);
  import rast_pkg::*;

  logic                valid_r;
  rast_key_t           key_r;
  logic [TIME_W-1:0]   stamp_r;
  logic                match_r;
  logic                stale_r;
  logic                old_r;

  logic [TIME_W-1:0]   age;
  logic [TIME_W-1:0]   period_ext;
  logic [TIME_W-1:0]   expiry_ext;
  logic                free_here;
  logic                claim;

  assign age        = cmd.now - stamp_r;
  assign period_ext = {{(TIME_W-PERIOD_W){1'b0}}, cmd.period};
  assign expiry_ext = {{(TIME_W-PERIOD_W-1){1'b0}}, cmd.period, 1'b0};

  // An entry that would expire counts as free for the store.
  assign free_here = !valid_r || old_r;
  assign claim     = free_here && !link_in.free_seen;

  assign link_out.hit       = link_in.hit || match_r;
  assign link_out.hit_stale = link_in.hit_stale || (match_r && stale_r);
  assign link_out.free_seen = link_in.free_seen || free_here;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      match_r <= 1'b0;
      stale_r <= 1'b0;
      old_r   <= 1'b0;
    end else begin
      if (cmd.eval) begin
        match_r <= valid_r && (key_r == cmd.key);
        stale_r <= age > period_ext;
        old_r   <= valid_r && (age > expiry_ext);
      end
      if (cmd.commit) begin
        if (cmd.any_match) begin
          if (match_r && stale_r) begin
            stamp_r <= cmd.now;
          end
        end else if (claim) begin
          valid_r <= 1'b1;
          key_r   <= cmd.key;
          stamp_r <= cmd.now;
        end else if (old_r) begin
          valid_r <= 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/repeat_alert_suppression_table.sv =====
`default_nettype none

// Repeat-alert suppression table.
// in_ch carries one alert request (time, server address, port, violation
// code, severity); out_ch returns one result per request: redundant and an
// outcome code (stored new, refreshed, suppressed, table full). cfg_ch
// writes the recheck period in milliseconds; write it only while idle.
// Each table entry lives in its own cell; the cells form a chain that
// carries the match summary and the lowest-free-slot pick from cell 0 up.
// After a request is taken, the EVAL state compares every cell against it
// and the COMMIT state updates the entries and registers the result.
// A new request is taken during a commit but not during a compare, as the
// compare/commit pair works on the shared entry state.
// Reset clears every entry's valid bit at once and loads the period with
// 30000; entry contents stay unknown until stored.
// When out_ch stalls, the finished result holds in the output register and
// the commit of a following request waits; a new request is still taken
// while the block is idle.
module repeat_alert_suppression_table #(
  parameter int TABLE_ENTRIES = rast_pkg::RAST_ENTRIES
) (
  input  wire            clk,
  input  wire            rst_n,
  rast_in_if.sink        in_ch,
  rast_out_if.source     out_ch,
  rast_cfg_if.sink       cfg_ch
);
  import rast_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_EVAL   = 3'b010,
    ST_COMMIT = 3'b100
  } state_t;

  state_t              state_r, state_nxt;
  logic [PERIOD_W-1:0] period_r;
  rast_key_t           key_r;
  logic [TIME_W-1:0]   now_r;
  logic                out_valid_r;
  logic                redundant_r;
  outcome_t            outcome_r;

  logic                in_acc;
  logic                commit_go;
  rast_cmd_t           cmd;
  rast_link_t          links [TABLE_ENTRIES+1];
  rast_link_t          tail;
  outcome_t            outcome_nxt;

  assign commit_go = (state_r == ST_COMMIT) && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = (state_r == ST_IDLE) || commit_go;
  assign in_acc = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign tail = links[TABLE_ENTRIES];

  assign cmd.eval      = (state_r == ST_EVAL);
  assign cmd.commit    = commit_go;
  assign cmd.any_match = tail.hit;
  assign cmd.key       = key_r;
  assign cmd.now       = now_r;
  assign cmd.period    = period_r;

  assign links[0] = '{hit: 1'b0, hit_stale: 1'b0, free_seen: 1'b0};

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    rast_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd),
      .link_in  (links[g]),
      .link_out (links[g+1])
    );
  end

  always_comb begin
    if (tail.hit) begin
      outcome_nxt = tail.hit_stale ? OUT_REFRESHED : OUT_SUPPRESSED;
    end else begin
      outcome_nxt = tail.free_seen ? OUT_STORED : OUT_FULL;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (commit_go) state_nxt = in_acc ? ST_EVAL : ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      period_r    <= PERIOD_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid) begin
        period_r <= cfg_ch.recheck_period_ms;
      end
      if (commit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: capture the request, hold the result.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      key_r <= '{addr: in_ch.server_addr, port: in_ch.server_port,
                 kind: in_ch.violation_code, level: in_ch.severity};
      now_r <= in_ch.now_ms;
    end
    if (commit_go) begin
      redundant_r <= tail.hit && !tail.hit_stale;
      outcome_r   <= outcome_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.redundant = redundant_r;
  assign out_ch.outcome   = outcome_r;

endmodule

`default_nettype wire

// ===== sv/rast_chk.sv =====
`default_nettype none

module rast_chk (
  input wire                         clk,
  input wire                         rst_n,
  input wire                         in_valid,
  input wire                         in_ready,
  input wire                         out_valid,
  input wire                         out_ready,
  input wire                         out_redundant,
  input wire [rast_pkg::OUTC_W-1:0]  out_outcome
);
  import rast_pkg::*;

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_outcome) && $stable(out_redundant))
    else $error("result changed while stalled");

  // A fresh result only rises after the compare and commit of a request that was taken.
  a_rose_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_acc, 3))
    else $error("result without matching request");

  // No request is taken during the compare cycle.
  a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("request taken during compare");

  // Suppression flag agrees with the outcome code.
  a_redundant_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_redundant == (out_outcome == OUT_SUPPRESSED)))
    else $error("redundant flag disagrees with outcome");

endmodule

bind repeat_alert_suppression_table rast_chk u_rast_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_redundant (out_ch.redundant),
  .out_outcome   (out_ch.outcome)
);

`default_nettype wire

// ===== bench/repeat_alert_suppression_table_tb.sv =====
module repeat_alert_suppression_table_tb;
  import rast_pkg::*;

  localparam int KEY_W          = $bits(rast_key_t);
  localparam int POOL_KEYS      = 40;
  localparam int PHASE_ALERTS   = 280;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_REPORTS    = 40;

  typedef struct packed {
    logic     redundant;
    outcome_t outcome;
  } alert_verdict_t;

  // Mirror of the alert table; one verdict per accepted request.
  class suppression_scoreboard;
    logic [PERIOD_W-1:0] period_ms;
    bit                  live [RAST_ENTRIES];
    rast_key_t           keys [RAST_ENTRIES];
    logic [TIME_W-1:0]   stamps [RAST_ENTRIES];
    alert_verdict_t      pending_verdicts [$];
    int                  errors;

    function new();
      period_ms = PERIOD_RESET;
      foreach (live[i]) live[i] = 1'b0;
      errors = 0;
    endfunction

    function int pending();
      return pending_verdicts.size();
    endfunction

    function void predict_alert(rast_key_t key, logic [TIME_W-1:0] now);
      logic [TIME_W-1:0] twice;
      alert_verdict_t    v;
      int                hit;
      hit = -1;
      foreach (live[i]) begin
        if (hit < 0 && live[i] && keys[i] == key) hit = i;
      end
      if (hit >= 0) begin
        if (now - stamps[hit] > TIME_W'(period_ms)) begin
          stamps[hit] = now;
          v = '{redundant: 1'b0, outcome: OUT_REFRESHED};
        end else begin
          v = '{redundant: 1'b1, outcome: OUT_SUPPRESSED};
        end
      end else begin
        twice = TIME_W'(period_ms) << 1;
        foreach (live[i]) begin
          if (live[i] && now - stamps[i] > twice) live[i] = 1'b0;
        end
        v = '{redundant: 1'b0, outcome: OUT_FULL};
        foreach (live[i]) begin
          if (v.outcome == OUT_FULL && !live[i]) begin
            live[i]   = 1'b1;
            keys[i]   = key;
            stamps[i] = now;
            v = '{redundant: 1'b0, outcome: OUT_STORED};
          end
        end
      end
      pending_verdicts.push_back(v);
    endfunction

    function void check_verdict(logic redundant, logic [OUTC_W-1:0] outcome);
      alert_verdict_t want;
      if (pending_verdicts.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $error("unexpected result: redundant=%0b outcome=%0d", redundant, outcome);
        return;
      end
      want = pending_verdicts.pop_front();
      if (redundant !== want.redundant) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $error("redundant: expected %0b, actual %0b", want.redundant, redundant);
      end
      if (outcome !== want.outcome) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $error("outcome: expected %0d, actual %0d", want.outcome, outcome);
      end
    endfunction

    // Random live entry, used to aim requests at the age boundaries.
    function bit pick_live(output rast_key_t key, output logic [TIME_W-1:0] stamp);
      int idx [$];
      int pick;
      foreach (live[i]) begin
        if (live[i]) idx.push_back(i);
      end
      if (idx.size() == 0) return 1'b0;
      pick  = idx[$urandom_range(0, idx.size() - 1)];
      key   = keys[pick];
      stamp = stamps[pick];
      return 1'b1;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  rast_in_if  in_ch ();
  rast_out_if out_ch ();
  rast_cfg_if cfg_ch ();

  repeat_alert_suppression_table dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  suppression_scoreboard sb;
  int                    tx_idle_pct;
  int                    rx_idle_pct;
  bit                    hold_off_req;
  logic [TIME_W-1:0]     wall_ms;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: random ready, plus one long hold-off on request.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end
      out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_verdict(out_ch.redundant, out_ch.outcome);
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // Called and returns at a falling edge; valid stays high for a back-to-back request.
  task automatic offer_alert(input rast_key_t key, input logic [TIME_W-1:0] now);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.now_ms         <= now;
    in_ch.server_addr    <= key.addr;
    in_ch.server_port    <= key.port;
    in_ch.violation_code <= key.kind;
    in_ch.severity       <= key.level;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.predict_alert(key, now);
    @(negedge clk);
  endtask

  task automatic write_period(input logic [PERIOD_W-1:0] value);
    cfg_ch.valid             <= 1'b1;
    cfg_ch.recheck_period_ms <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    sb.period_ms = value;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic run_random_phase(input int n_alerts);
    rast_key_t          pool [POOL_KEYS];
    rast_key_t          key;
    logic [KEY_W-1:0]   flip;
    logic [TIME_W-1:0]  p;
    logic [TIME_W-1:0]  st;
    logic [TIME_W-1:0]  step;
    int                 sent;
    int                 burst;
    int                 base;
    int                 r;
    p = TIME_W'(sb.period_ms);
    // Neighbors share address or port so that single-field differences get compared.
    for (int i = 0; i < POOL_KEYS; i++) begin
      pool[i].addr  = (i % 4 == 0) ? $urandom : pool[i-1].addr;
      pool[i].port  = (i % 2 == 0) ? PORT_W'($urandom) : pool[i-1].port;
      pool[i].kind  = KIND_W'($urandom);
      pool[i].level = LEVEL_W'($urandom);
    end
    sent = 0;
    while (sent < n_alerts) begin
      r = $urandom_range(0, 99);
      if (r < 30) begin
        // fill burst: mostly distinct alerts close together, which can overflow the table
        burst = $urandom_range(20, 45);
        base  = $urandom_range(0, POOL_KEYS - 1);
        for (int j = 0; j < burst; j++) begin
          if ($urandom_range(0, 2) == 0)
            wall_ms += TIME_W'($urandom_range(0, sb.period_ms >> 6));
          key = ($urandom_range(0, 3) == 0) ? pool[$urandom_range(0, POOL_KEYS - 1)]
                                            : pool[(base + j) % POOL_KEYS];
          offer_alert(key, wall_ms);
        end
        sent += burst;
      end else if (r < 65) begin
        // churn: repeats with time steps around the period and its double
        burst = $urandom_range(5, 20);
        for (int j = 0; j < burst; j++) begin
          r = $urandom_range(0, 99);
          if (r < 45)      step = TIME_W'($urandom_range(0, sb.period_ms >> 4));
          else if (r < 60) step = '0;
          else if (r < 72) step = TIME_W'($urandom_range(0, sb.period_ms));
          else if (r < 80) step = p;
          else if (r < 86) step = p + 1;
          else if (r < 91) step = p + p;
          else if (r < 95) step = p + p + 1;
          else             step = TIME_W'($urandom_range(0, sb.period_ms)) * 3;
          wall_ms += step;
          offer_alert(pool[$urandom_range(0, POOL_KEYS - 1)], wall_ms);
        end
        sent += burst;
      end else if (r < 85) begin
        if (!sb.pick_live(key, st)) begin
          offer_alert(pool[$urandom_range(0, POOL_KEYS - 1)], wall_ms);
          sent++;
        end else if ($urandom_range(0, 1) == 0) begin
          // age equal to the period is still a repeat; one more ms refreshes
          offer_alert(key, st + p);
          offer_alert(key, st + p + 1);
          sent += 2;
        end else begin
          // new alerts at exactly twice the period keep the entry; one ms later drops it
          offer_alert(rast_key_t'(KEY_W'({$urandom, $urandom})), st + p + p);
          offer_alert(rast_key_t'(KEY_W'({$urandom, $urandom})), st + p + p + 1);
          sent += 2;
        end
      end else if (r < 93) begin
        flip = '0;
        flip[$urandom_range(0, KEY_W - 1)] = 1'b1;
        key = rast_key_t'(pool[$urandom_range(0, POOL_KEYS - 1)] ^ flip);
        offer_alert(key, wall_ms);
        sent++;
      end else begin
        // noise: any key at any time, sometimes moving the clock backwards
        step = {$urandom, $urandom};
        offer_alert(rast_key_t'(KEY_W'({$urandom, $urandom})), step);
        if ($urandom_range(0, 1) == 0) wall_ms = step;
        sent++;
      end
    end
  endtask

  initial begin
    rast_key_t a_key;
    rast_key_t m_key;
    rast_key_t z_key;
    sb = new();
    rst_n                    = 1'b0;
    in_ch.valid              = 1'b0;
    in_ch.now_ms             = '0;
    in_ch.server_addr        = '0;
    in_ch.server_port        = '0;
    in_ch.violation_code     = '0;
    in_ch.severity           = '0;
    out_ch.ready             = 1'b0;
    cfg_ch.valid             = 1'b0;
    cfg_ch.recheck_period_ms = '0;
    hold_off_req             = 1'b0;
    tx_idle_pct              = 35;
    rx_idle_pct              = 54;
    wall_ms                  = 64'd200000;
    a_key = '{addr: 32'h0A00_0001, port: 16'd443, kind: 3'd1, level: 2'd2};
    m_key = '{addr: '1, port: '1, kind: '1, level: '1};
    z_key = '{addr: '0, port: '0, kind: '0, level: '0};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset period of 30000 ms.
    offer_alert(a_key, 64'd1000);
    offer_alert(a_key, 64'd31000);
    offer_alert(a_key, 64'd31001);
    offer_alert(z_key, 64'd0);
    offer_alert(m_key, 64'd60000);
    offer_alert('{addr: '1, port: '1, kind: 3'd6, level: '1}, 64'd60001);
    offer_alert('{addr: '1, port: '1, kind: '1, level: 2'd2}, 64'd60001);
    offer_alert('{addr: '1, port: 16'hFFFE, kind: '1, level: '1}, 64'd60001);
    offer_alert('{addr: 32'hFFFF_FFFE, port: '1, kind: '1, level: '1}, 64'd60001);
    offer_alert(m_key, 64'd90000);
    offer_alert(m_key, 64'hFFFF_FFFF_FFFF_FFFF);
    offer_alert(m_key, 64'd0);
    offer_alert(a_key, 64'h8000_0000_0000_0000);
    offer_alert('{addr: 32'h0A00_0001, port: 16'd443, kind: 3'd1, level: 2'd1},
                64'h8000_0000_0000_0000);

    run_random_phase(PHASE_ALERTS);

    drain_results();
    write_period(32'd1);
    run_random_phase(PHASE_ALERTS);

    tx_idle_pct = 54;
    rx_idle_pct = 35;
    drain_results();
    write_period(32'hFFFF_FFFF);
    run_random_phase(PHASE_ALERTS);

    drain_results();
    write_period($urandom_range(2, 100000));
    run_random_phase(PHASE_ALERTS);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    drain_results();
    write_period(32'd1000);
    run_random_phase(PHASE_ALERTS);

    drain_results();
    write_period(32'd7);
    hold_off_req = 1'b1;
    run_random_phase(PHASE_ALERTS);

    drain_results();
    if (sb.errors == 0 && sb.pending() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
